FILE: hdl/sptt_pkg.sv
package sptt_pkg;

   // default table depth
   localparam int MAX_TERMS_DEF = 32;

   localparam int COEF_W = 32;
   localparam int POW_W  = 16;

   // operation codes
   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_CLEAR = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   // result status codes
   localparam logic [2:0] ST_MERGED   = 3'd0;
   localparam logic [2:0] ST_INSERTED = 3'd1;
   localparam logic [2:0] ST_REMOVED  = 3'd2;
   localparam logic [2:0] ST_DROPPED  = 3'd3;
   localparam logic [2:0] ST_TERM     = 3'd4;
   localparam logic [2:0] ST_EMPTY    = 3'd5;

   typedef logic [5:0] cnt_out_type;

   typedef struct packed {
      logic [1:0]               func;
      logic signed [COEF_W-1:0] term_coefficient;
      logic [POW_W-1:0]         term_power;
   } req_type;

   typedef struct packed {
      logic [2:0]               status;
      logic signed [COEF_W-1:0] out_coefficient;
      logic [POW_W-1:0]         out_power;
      cnt_out_type              entry_count;
      logic                     last;
   } rsp_type;

endpackage

FILE: hdl/sptt_store.sv
module sptt_store #(
   parameter int DEPTH = sptt_pkg::MAX_TERMS_DEF,
   parameter int IDX_W = $clog2(sptt_pkg::MAX_TERMS_DEF)
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [IDX_W-1:0]                 wr_addr,
   input  logic [sptt_pkg::COEF_W-1:0]      wr_coef,
   input  logic [sptt_pkg::POW_W-1:0]       wr_pow,
   input  logic [IDX_W-1:0]                 rd_addr,
   output logic [sptt_pkg::COEF_W-1:0]      rd_coef,
   output logic [sptt_pkg::POW_W-1:0]       rd_pow
);

   logic [sptt_pkg::COEF_W-1:0] coef_mem [DEPTH];
   logic [sptt_pkg::POW_W-1:0]  pow_mem  [DEPTH];

   // one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         coef_mem[wr_addr] <= wr_coef;
         pow_mem[wr_addr]  <= wr_pow;
      end
   end

   // one registered read port
   always_ff @(posedge clock) begin
      rd_coef <= coef_mem[rd_addr];
      rd_pow  <= pow_mem[rd_addr];
   end

endmodule

FILE: hdl/sparse_polynomial_term_table.sv
// Sparse polynomial term table. Terms (coefficient, power) are kept in insertion
// order in a single-port-read memory, and one sequencer walks that memory one
// entry per cycle, sharing a single 32-bit adder and power compare. An add
// searches the stored terms in order; when the matching term sums to zero, the
// tail after it moves down one place. An insert into an empty table, a clear and
// an empty readout never make the block busy; a readout gives one term per
// cycle and never stalls.
// Every result appears for exactly one cycle with rsp_strobe high and
// must be taken then: there is no way to stall the result side. rsp_data.last
// marks the final result of each transaction; func code 3 gives no result.
module sparse_polynomial_term_table #(
   parameter int MAX_TERMS = sptt_pkg::MAX_TERMS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sptt_pkg::req_type req_data,
   output logic              rsp_strobe,
   output sptt_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CNT_W = $clog2(MAX_TERMS + 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_SHIFT  = 2'd2;
   localparam logic [1:0] S_READ   = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            rdx_ff, rdx_in;
   logic [sptt_pkg::COEF_W-1:0] coef_ff, coef_in;
   logic [sptt_pkg::POW_W-1:0]  pow_ff, pow_in;
   logic                        strobe_ff, strobe_in;
   sptt_pkg::rsp_type           rsp_ff, rsp_in;

   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [sptt_pkg::COEF_W-1:0] wr_coef;
   logic [sptt_pkg::POW_W-1:0]  wr_pow;
   logic [IDX_W-1:0]            rd_addr;
   logic [sptt_pkg::COEF_W-1:0] rd_coef;
   logic [sptt_pkg::POW_W-1:0]  rd_pow;

   logic [CNT_W-1:0]            rdx_nx;
   logic [CNT_W-1:0]            shift_dst;
   logic                        rd_last;
   logic [sptt_pkg::COEF_W-1:0] sum;

   sptt_store #(
      .DEPTH (MAX_TERMS),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_coef (wr_coef),
      .wr_pow  (wr_pow),
      .rd_addr (rd_addr),
      .rd_coef (rd_coef),
      .rd_pow  (rd_pow)
   );

   // shared adder and walk pointer arithmetic
   assign sum       = rd_coef + coef_ff;
   assign rdx_nx    = rdx_ff + CNT_W'(1);
   assign shift_dst = rdx_ff - CNT_W'(1);
   assign rd_last   = (rdx_nx == count_ff);
   assign rd_addr   = rdx_in[IDX_W-1:0];

   // sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      rdx_in    = rdx_nx;
      coef_in   = coef_ff;
      pow_in    = pow_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      wr_en     = 1'b0;
      wr_addr   = count_ff[IDX_W-1:0];
      wr_coef   = coef_ff;
      wr_pow    = pow_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               coef_in = req_data.term_coefficient;
               pow_in  = req_data.term_power;
               case (req_data.func)
                  sptt_pkg::FUNC_ADD: begin
                     if (count_ff == '0) begin
                        wr_en                  = 1'b1;
                        wr_coef                = req_data.term_coefficient;
                        wr_pow                 = req_data.term_power;
                        count_in               = count_ff + CNT_W'(1);
                        strobe_in              = 1'b1;
                        rsp_in.status          = sptt_pkg::ST_INSERTED;
                        rsp_in.out_coefficient = req_data.term_coefficient;
                        rsp_in.out_power       = req_data.term_power;
                        rsp_in.last            = 1'b1;
                     end else begin
                        rdx_in   = '0;
                        state_in = S_SEARCH;
                     end
                  end
                  sptt_pkg::FUNC_CLEAR: begin
                     count_in               = '0;
                     strobe_in              = 1'b1;
                     rsp_in.status          = sptt_pkg::ST_EMPTY;
                     rsp_in.out_coefficient = '0;
                     rsp_in.out_power       = '0;
                     rsp_in.last            = 1'b1;
                  end
                  sptt_pkg::FUNC_READ: begin
                     if (count_ff == '0) begin
                        strobe_in              = 1'b1;
                        rsp_in.status          = sptt_pkg::ST_EMPTY;
                        rsp_in.out_coefficient = '0;
                        rsp_in.out_power       = '0;
                        rsp_in.last            = 1'b1;
                     end else begin
                        rdx_in   = '0;
                        state_in = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // compare one stored power per cycle
         S_SEARCH: begin
            if (rd_pow == pow_ff) begin
               if (sum != '0) begin
                  wr_en                  = 1'b1;
                  wr_addr                = rdx_ff[IDX_W-1:0];
                  wr_coef                = sum;
                  strobe_in              = 1'b1;
                  rsp_in.status          = sptt_pkg::ST_MERGED;
                  rsp_in.out_coefficient = sum;
                  rsp_in.out_power       = pow_ff;
                  rsp_in.last            = 1'b1;
                  state_in               = S_IDLE;
               end else begin
                  state_in = S_SHIFT;
               end
            end else if (rd_last) begin
               strobe_in              = 1'b1;
               rsp_in.out_coefficient = coef_ff;
               rsp_in.out_power       = pow_ff;
               rsp_in.last            = 1'b1;
               state_in               = S_IDLE;
               if (count_ff < CNT_W'(MAX_TERMS)) begin
                  wr_en         = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
                  rsp_in.status = sptt_pkg::ST_INSERTED;
               end else begin
                  rsp_in.status = sptt_pkg::ST_DROPPED;
               end
            end
         end

         // move the tail down one place after a removal
         S_SHIFT: begin
            if (rdx_ff < count_ff) begin
               wr_en   = 1'b1;
               wr_addr = shift_dst[IDX_W-1:0];
               wr_coef = rd_coef;
               wr_pow  = rd_pow;
            end else begin
               count_in               = count_ff - CNT_W'(1);
               strobe_in              = 1'b1;
               rsp_in.status          = sptt_pkg::ST_REMOVED;
               rsp_in.out_coefficient = '0;
               rsp_in.out_power       = pow_ff;
               rsp_in.last            = 1'b1;
               state_in               = S_IDLE;
            end
         end

         // one stored term per cycle
         S_READ: begin
            strobe_in              = 1'b1;
            rsp_in.status          = sptt_pkg::ST_TERM;
            rsp_in.out_coefficient = rd_coef;
            rsp_in.out_power       = rd_pow;
            rsp_in.last            = rd_last;
            if (rd_last) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in.entry_count = sptt_pkg::cnt_out_type'(count_in);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rdx_ff  <= rdx_in;
      coef_ff <= coef_in;
      pow_ff  <= pow_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // table never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TERMS))
      else $error("stored count above table depth");

   // a clear transaction answers next cycle with an empty table
   a_clear_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.func == sptt_pkg::FUNC_CLEAR) |=>
      (rsp_strobe && rsp_data.status == sptt_pkg::ST_EMPTY &&
       rsp_data.entry_count == '0 && rsp_data.last))
      else $error("clear did not answer with empty table");

   // a result that is not the last keeps the block busy
   a_nonlast_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |-> busy)
      else $error("non-final result while idle");

   // an insert grows the table by one
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == sptt_pkg::ST_INSERTED) |->
      (count_ff == CNT_W'($past(count_ff) + CNT_W'(1))))
      else $error("insert did not grow the table by one");

endmodule

FILE: dv/sparse_polynomial_term_table_scoreboard.sv
module sparse_polynomial_term_table_scoreboard #(
   parameter int MAX_TERMS = sptt_pkg::MAX_TERMS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  sptt_pkg::req_type req_data,
   input  logic              rsp_strobe,
   input  sptt_pkg::rsp_type rsp_data,
   output int                error_count,
   output int                results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow copy of the term table
   logic signed [sptt_pkg::COEF_W-1:0] coef_tab [MAX_TERMS];
   logic [sptt_pkg::POW_W-1:0]         pow_tab  [MAX_TERMS];
   int                                 n_terms = 0;

   // results owed by the block, oldest first
   sptt_pkg::rsp_type expected_terms [$];
   int                mismatches = 0;

   // one result as the table stands after the step
   function automatic sptt_pkg::rsp_type term_result(
      input logic [2:0]                 status,
      input logic [sptt_pkg::COEF_W-1:0] coef,
      input logic [sptt_pkg::POW_W-1:0]  power,
      input logic                       last);
      sptt_pkg::rsp_type r;
      r.status          = status;
      r.out_coefficient = coef;
      r.out_power       = power;
      r.entry_count     = n_terms[5:0];
      r.last            = last;
      return r;
   endfunction

   // append one owed result at the tail
   task automatic add_expected(input sptt_pkg::rsp_type r);
      expected_terms.insert(expected_terms.size(), r);
   endtask

   // apply one accepted transaction to the shadow table and queue its results
   task automatic predict_request(input sptt_pkg::req_type r);
      logic signed [sptt_pkg::COEF_W-1:0] sum;
      int hit;
      hit = -1;
      case (r.func)
         sptt_pkg::FUNC_ADD: begin
            for (int i = 0; i < n_terms; i++)
               if (hit < 0 && pow_tab[i] == r.term_power) hit = i;
            if (hit >= 0) begin
               sum = coef_tab[hit] + r.term_coefficient;
               if (sum != 0) begin
                  coef_tab[hit] = sum;
                  add_expected(term_result(sptt_pkg::ST_MERGED, sum, r.term_power, 1'b1));
               end else begin
                  // zero sum: drop the entry and close the gap
                  for (int j = hit; j + 1 < n_terms; j++) begin
                     coef_tab[j] = coef_tab[j + 1];
                     pow_tab[j]  = pow_tab[j + 1];
                  end
                  n_terms--;
                  add_expected(term_result(sptt_pkg::ST_REMOVED, '0, r.term_power, 1'b1));
               end
            end else if (n_terms < MAX_TERMS) begin
               coef_tab[n_terms] = r.term_coefficient;
               pow_tab[n_terms]  = r.term_power;
               n_terms++;
               add_expected(term_result(sptt_pkg::ST_INSERTED, r.term_coefficient,
                                        r.term_power, 1'b1));
            end else begin
               add_expected(term_result(sptt_pkg::ST_DROPPED, r.term_coefficient,
                                        r.term_power, 1'b1));
            end
         end
         sptt_pkg::FUNC_CLEAR: begin
            n_terms = 0;
            add_expected(term_result(sptt_pkg::ST_EMPTY, '0, '0, 1'b1));
         end
         sptt_pkg::FUNC_READ: begin
            if (n_terms == 0) begin
               add_expected(term_result(sptt_pkg::ST_EMPTY, '0, '0, 1'b1));
            end else begin
               for (int i = 0; i < n_terms; i++)
                  add_expected(term_result(sptt_pkg::ST_TERM, coef_tab[i], pow_tab[i],
                                           i == n_terms - 1));
            end
         end
         default: begin
            // unused code: no result and no change
         end
      endcase
   endtask

   task automatic field_check(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s expected %0d actual %0d", name, $signed(want), $signed(got));
         mismatches++;
      end
   endtask

   // compare one result against the oldest expectation
   task automatic check_result(input sptt_pkg::rsp_type got);
      sptt_pkg::rsp_type want;
      if (expected_terms.size() == 0) begin
         $error("unexpected result: status %0d power %0d", got.status, got.out_power);
         mismatches++;
         return;
      end
      want = expected_terms.pop_front();
      field_check("status", 32'(want.status), 32'(got.status));
      field_check("out_coefficient", want.out_coefficient, got.out_coefficient);
      field_check("out_power", 32'(want.out_power), 32'(got.out_power));
      field_check("entry_count", 32'(want.entry_count), 32'(got.entry_count));
      field_check("last", 32'(want.last), 32'(got.last));
   endtask

   // watch both channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         expected_terms.delete();
         n_terms = 0;
      end else begin
         if (rsp_strobe) check_result(rsp_data);
         if (start && !busy) predict_request(req_data);
      end
      error_count <= mismatches;
      results_due <= expected_terms.size();
   end

endmodule

FILE: dv/sparse_polynomial_term_table_tb.sv
module sparse_polynomial_term_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         ITEM_TARGET  = 350;
   localparam int         POOL_SIZE    = 40;
   localparam int         CYCLE_LIMIT  = 400000;
   localparam int         DRAIN_CYCLES = 2 * sptt_pkg::MAX_TERMS_DEF + 16;
   localparam logic [1:0] FUNC_UNUSED  = 2'd3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   sptt_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   sptt_pkg::rsp_type rsp_data;

   int error_count;
   int results_due;
   int cycle_count = 0;
   int n_add = 0;
   int n_clear = 0;
   int n_read = 0;
   int n_unused = 0;
   int burst_left = 0;

   // powers the random part draws from, and the running sum sent to each
   logic [sptt_pkg::POW_W-1:0]  pool_power [POOL_SIZE];
   logic [sptt_pkg::COEF_W-1:0] pool_sum   [POOL_SIZE];

   sparse_polynomial_term_table i_dut (
      .clock,
      .reset,
      .start,
      .busy,
      .req_data,
      .rsp_strobe,
      .rsp_data
   );

   sparse_polynomial_term_table_scoreboard i_scoreboard (
      .clock,
      .reset,
      .start,
      .busy,
      .req_data,
      .rsp_strobe,
      .rsp_data,
      .error_count,
      .results_due
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sparse_polynomial_term_table_tb: errors");
         $finish;
      end
   end

   function automatic sptt_pkg::req_type mk_request(input logic [1:0] f,
                                                    input logic [sptt_pkg::COEF_W-1:0] c,
                                                    input logic [sptt_pkg::POW_W-1:0] p);
      sptt_pkg::req_type r;
      r.func             = f;
      r.term_coefficient = c;
      r.term_power       = p;
      return r;
   endfunction

   // drive one transaction until accepted, then maybe end the burst with a gap
   task automatic send_request(input sptt_pkg::req_type r);
      int gap;
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      case (r.func)
         sptt_pkg::FUNC_ADD:   n_add++;
         sptt_pkg::FUNC_CLEAR: n_clear++;
         sptt_pkg::FUNC_READ:  n_read++;
         default:              n_unused++;
      endcase
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 8);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off until every owed result has come back
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   task automatic add_pool(input int k, input logic [sptt_pkg::COEF_W-1:0] coef);
      send_request(mk_request(sptt_pkg::FUNC_ADD, coef, pool_power[k]));
      pool_sum[k] += coef;
   endtask

   task automatic clear_table();
      send_request(mk_request(sptt_pkg::FUNC_CLEAR, $urandom, 16'($urandom)));
      foreach (pool_sum[k]) pool_sum[k] = '0;
   endtask

   // coefficient mix: cancellations, extremes, small values, anything
   function automatic logic [sptt_pkg::COEF_W-1:0] pick_coef(input int k);
      case ($urandom_range(0, 9))
         0, 1, 2: return (pool_sum[k] == 0) ? $urandom : -pool_sum[k];
         3:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         4, 5:    return $urandom_range(0, 20) - 10;
         default: return $urandom;
      endcase
   endfunction

   // fill past capacity, knock a few out, refill
   task automatic fill_table();
      int k;
      clear_table();
      for (int i = 0; i < sptt_pkg::MAX_TERMS_DEF + 4; i++) add_pool(i, $urandom | 32'd1);
      for (int i = sptt_pkg::MAX_TERMS_DEF; i < POOL_SIZE; i++) pool_sum[i] = '0;
      send_request(mk_request(sptt_pkg::FUNC_READ, $urandom, 16'($urandom)));
      repeat ($urandom_range(1, 3)) begin
         k = $urandom_range(0, sptt_pkg::MAX_TERMS_DEF - 1);
         if (pool_sum[k] != 0) add_pool(k, -pool_sum[k]);
      end
      add_pool(sptt_pkg::MAX_TERMS_DEF + $urandom_range(0, 3), $urandom);
      send_request(mk_request(sptt_pkg::FUNC_READ, '0, '0));
   endtask

   // adds over a few hot powers, some cold ones, then maybe a readout
   task automatic mixed_adds();
      int k;
      repeat ($urandom_range(4, 16)) begin
         k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, POOL_SIZE - 1)
                                         : $urandom_range(0, 7);
         add_pool(k, pick_coef(k));
      end
      if ($urandom_range(0, 1))
         send_request(mk_request(sptt_pkg::FUNC_READ, $urandom, 16'($urandom)));
   endtask

   // unused codes, stray powers, readouts and clears
   task automatic noise_requests();
      repeat ($urandom_range(2, 6)) begin
         case ($urandom_range(0, 3))
            0: send_request(mk_request(FUNC_UNUSED, $urandom, 16'($urandom)));
            1: send_request(mk_request(sptt_pkg::FUNC_ADD, $urandom, 16'($urandom)));
            2: send_request(mk_request(sptt_pkg::FUNC_READ, $urandom, 16'($urandom)));
            default: clear_table();
         endcase
      end
   endtask

   // stimulus
   initial begin
      logic [sptt_pkg::POW_W-1:0] base;
      base = 16'($urandom);
      for (int k = 0; k < POOL_SIZE; k++) begin
         pool_power[k] = base + 16'(k) * 16'h9e37;
         pool_sum[k]   = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, zero term, wrap, removal with shift, unused code
      send_request(mk_request(sptt_pkg::FUNC_READ, '0, '0));
      send_request(mk_request(sptt_pkg::FUNC_CLEAR, 32'hffff_ffff, 16'hffff));
      send_request(mk_request(sptt_pkg::FUNC_ADD, '0, '0));
      send_request(mk_request(sptt_pkg::FUNC_ADD, '0, '0));
      send_request(mk_request(sptt_pkg::FUNC_ADD, 32'h7fff_ffff, 16'hffff));
      send_request(mk_request(sptt_pkg::FUNC_ADD, 32'd1, 16'hffff));
      send_request(mk_request(sptt_pkg::FUNC_ADD, 32'h8000_0000, 16'hffff));
      send_request(mk_request(sptt_pkg::FUNC_ADD, -32'sd5, 16'd1));
      send_request(mk_request(sptt_pkg::FUNC_ADD, 32'd7, 16'd2));
      send_request(mk_request(sptt_pkg::FUNC_ADD, 32'd9, 16'd3));
      send_request(mk_request(sptt_pkg::FUNC_ADD, 32'd5, 16'd1));
      send_request(mk_request(sptt_pkg::FUNC_READ, '0, '0));
      send_request(mk_request(FUNC_UNUSED, 32'hffff_ffff, 16'hffff));
      send_request(mk_request(sptt_pkg::FUNC_ADD, 32'hffff_ffff, 16'd2));
      send_request(mk_request(sptt_pkg::FUNC_READ, '0, '0));
      send_request(mk_request(sptt_pkg::FUNC_CLEAR, '0, '0));
      send_request(mk_request(sptt_pkg::FUNC_READ, '0, '0));

      // random part, starting with a full table and a drained pause
      fill_table();
      wait_drained();
      while (n_add + n_clear + n_read < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0: begin
               fill_table();
               if ($urandom_range(0, 1)) wait_drained();
            end
            1:       noise_requests();
            default: mixed_adds();
         endcase
      end

      // drain and verdict
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d adds, %0d clears, %0d readouts, %0d unused-code requests",
               n_add, n_clear, n_read, n_unused);
      $display("in %0d cycles, with full-table drops and zero-sum removals", cycle_count);
      if (error_count == 0) begin
         $display("sparse_polynomial_term_table_tb: clean");
      end else begin
         $display("sparse_polynomial_term_table_tb: errors");
      end
      $finish;
   end

endmodule
